[hw/rtl/lpcinv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpcinv_pkg
// Shared types and constants for the lpc inverse fir filter and its tap cells.
// ----------------------------------------------------------------------------
package lpcinv_pkg;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned COEF_W   = 20;
	localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;
	localparam int unsigned FRAC_W   = 16;
	localparam int unsigned ORDER_W  = 6;
	localparam int unsigned IDX_W    = 5;
	localparam int unsigned OP_W     = 2;

	localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	// per-cycle commands broadcast to every tap cell
	typedef struct packed {
		logic filt;
		logic load;
		logic clr;
		logic adv;
	} cell_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/lpcinv_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpcinv_cell
// One filter tap: holds a coefficient and a history sample, registers their
// product and adds it into the partial sum passing down the chain.
// ----------------------------------------------------------------------------
module lpcinv_cell import lpcinv_pkg::*; #(
	parameter int unsigned TAP   = 0,
	parameter int unsigned ACC_W = 42
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  cell_ctl_t                 ctl,
	input  wire                       tap_on,
	input  wire [IDX_W-1:0]           coef_index,
	input  wire signed [COEF_W-1:0]   coef_value,
	input  wire signed [SAMPLE_W-1:0] hist_in,
	output logic signed [SAMPLE_W-1:0] hist_out,
	input  wire signed [ACC_W-1:0]    acc_in,
	input  wire                       vld_in,
	output logic signed [ACC_W-1:0]   acc_out,
	output logic                      vld_out
);

	logic signed [COEF_W-1:0]   coef_q;
	logic signed [SAMPLE_W-1:0] hist_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       vld_q;
	logic                       coef_hit;
	logic signed [ACC_W-1:0]    term;

	assign coef_hit = ctl.load && ({2'b00, coef_index} == 7'(TAP));
	assign term = tap_on ? {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
			hist_q <= '0;
		end else begin
			if (coef_hit) begin
				coef_q <= coef_value;
			end
			// product uses the history before this beat shifts it
			if (ctl.filt) begin
				hist_q <= hist_in;
			end else if (ctl.clr) begin
				hist_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.filt) begin
			prod_q <= coef_q * hist_q;
		end
		if (ctl.adv) begin
			acc_q <= acc_in + term;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.adv) begin
			vld_q <= vld_in;
		end
	end

	assign hist_out = hist_q;
	assign acc_out  = acc_q;
	assign vld_out  = vld_q;

endmodule
`default_nettype wire

[hw/rtl/lpc_inverse_fir_filter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_inverse_fir_filter
// All-zero lpc inverse filter built as a chain of tap cells; the partial sum
// ripples one cell per cycle, then is rounded and saturated to 16 bits.
// ----------------------------------------------------------------------------
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid/in_ready, opcode, sample_in,        | input
//          | coef_index, coef_value                       |
//  out     | out_valid/out_ready, sample_out, saturated   | output
//  cfg     | cfg_we, cfg_data (order)                     | input
//
// a filter beat keeps the block busy while it registers the tap products,
// passes the sum down the cell chain and rounds it into the output register.
// load and clear beats give no result and leave the block ready.
// reset clears order, coefficients and history at once; no sweep is needed.
// a held output result stalls all cells once the next sum reaches the tail.
module lpc_inverse_fir_filter import lpcinv_pkg::*; #(
	parameter int unsigned MAX_TAPS = 32
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire [OP_W-1:0]            opcode,
	input  wire signed [SAMPLE_W-1:0] sample_in,
	input  wire [IDX_W-1:0]           coef_index,
	input  wire signed [COEF_W-1:0]   coef_value,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic                      saturated,
	input  wire                       cfg_we,
	input  wire [ORDER_W-1:0]         cfg_data
);

	localparam int unsigned ACC_W = PROD_W + 1 + $clog2(MAX_TAPS) + 1;
	localparam int unsigned Y_W   = ACC_W - FRAC_W;

	logic [ORDER_W-1:0]         order_q;
	logic                       busy_q;
	logic                       launch_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic                       saturated_q;

	logic                       accept;
	logic                       load_out;
	cell_ctl_t                  ctl;

	logic signed [SAMPLE_W-1:0] hist [MAX_TAPS+1];
	logic signed [ACC_W-1:0]    acc  [MAX_TAPS+1];
	logic                       vld  [MAX_TAPS+1];

	logic signed [ACC_W-1:0]    rnd;
	logic signed [Y_W-1:0]      y;
	logic                       ovf;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;

	assign load_out = vld[MAX_TAPS] && (!out_valid_q || out_ready);

	always_comb begin
		ctl.filt = accept && (opcode == OP_FILTER);
		ctl.load = accept && (opcode == OP_LOAD);
		ctl.clr  = accept && (opcode == OP_CLEAR);
		ctl.adv  = !(vld[MAX_TAPS] && !load_out);
	end

	// head of the chain: input sample as q27.16 when MAX_TAPS is 32
	assign hist[0] = sample_in;
	assign acc[0]  = {{(ACC_W-SAMPLE_W-FRAC_W){x_q[SAMPLE_W-1]}}, x_q, {FRAC_W{1'b0}}};
	assign vld[0]  = launch_q;

	for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
		logic tap_on;
		assign tap_on = {1'b0, order_q} > 7'(k);

		lpcinv_cell #(
			.TAP   (k),
			.ACC_W (ACC_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.tap_on     (tap_on),
			.coef_index (coef_index),
			.coef_value (coef_value),
			.hist_in    (hist[k]),
			.hist_out   (hist[k+1]),
			.acc_in     (acc[k]),
			.vld_in     (vld[k]),
			.acc_out    (acc[k+1]),
			.vld_out    (vld[k+1])
		);
	end

	// round half up, then clip when the upper bits disagree with the sign
	assign rnd = acc[MAX_TAPS] + ACC_W'(32768);
	assign y   = rnd[ACC_W-1:FRAC_W];
	assign ovf = !((&y[Y_W-1:SAMPLE_W-1]) || !(|y[Y_W-1:SAMPLE_W-1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q     <= '0;
			busy_q      <= 1'b0;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				order_q <= cfg_data;
			end
			launch_q <= ctl.filt;
			if (ctl.filt) begin
				busy_q <= 1'b1;
			end else if (load_out) begin
				busy_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.filt) begin
			x_q <= sample_in;
		end
		if (load_out) begin
			saturated_q <= ovf;
			if (ovf) begin
				sample_out_q <= y[Y_W-1] ? 16'sh8000 : 16'sh7fff;
			end else begin
				sample_out_q <= y[SAMPLE_W-1:0];
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign saturated  = saturated_q;

endmodule
`default_nettype wire

[dv/lpc_inverse_fir_filter_test.sv]
// ----------------------------------------------------------------------------
// lpc_inverse_fir_filter_test
// Self-checking bench for the lpc inverse fir filter. A scoreboard class keeps
// its own coefficient table, sample history and tap count, predicts each
// filtered beat exactly (Q4.16 taps), checks sample_out, saturated in order.
// Directed beats cover extremes, saturation, rounding ties and every opcode.
// Random phases run at several orders, most with random gaps on both channels.
// ----------------------------------------------------------------------------
module lpc_inverse_fir_filter_test;
	import lpcinv_pkg::*;

	localparam int NUM_TAPS = 32;
	localparam int LIMIT = 600000;
	localparam int SETTLE = 40;
	localparam int PHASES = 8;
	localparam int BEATS_PER_PHASE = 185;
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       sat;
	} filt_result_t;

	class fir_scoreboard;
		longint       coef_tab[NUM_TAPS];
		longint       history[NUM_TAPS];
		int           taps_used;
		int           errors;
		filt_result_t expected_q[$];

		function void set_order(logic [ORDER_W-1:0] v);
			taps_used = (v > NUM_TAPS) ? NUM_TAPS : int'(v);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_beat(logic [OP_W-1:0] op, logic signed [SAMPLE_W-1:0] s,
				logic [IDX_W-1:0] idx, logic signed [COEF_W-1:0] c);
			longint       acc;
			longint       r;
			filt_result_t res;
			case (op)
				OP_LOAD: begin
					if (idx < NUM_TAPS)
						coef_tab[idx] = longint'(c);
				end
				OP_CLEAR: begin
					foreach (history[k])
						history[k] = 0;
				end
				OP_FILTER: begin
					acc = longint'(s) * 65536;
					for (int k = 0; k < taps_used; k++)
						acc += coef_tab[k] * history[k];
					// arithmetic shift floors, so ties go toward plus infinity
					r = (acc + 32768) >>> FRAC_W;
					res.sat = 1'b1;
					if (r > 32767)
						res.sample = 16'sh7fff;
					else if (r < -32768)
						res.sample = 16'sh8000;
					else begin
						res.sample = r[SAMPLE_W-1:0];
						res.sat = 1'b0;
					end
					// the whole chain shifts whatever the order
					for (int k = NUM_TAPS - 1; k > 0; k--)
						history[k] = history[k-1];
					history[0] = longint'(s);
					expected_q.push_back(res);
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic signed [SAMPLE_W-1:0] y, logic sat);
			filt_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result sample_out=%0d saturated=%0b", $time, y, sat);
				return;
			end
			want = expected_q.pop_front();
			if (y !== want.sample) begin
				errors++;
				$display("%0t: sample_out expected %0d actual %0d", $time, want.sample, y);
			end
			if (sat !== want.sat) begin
				errors++;
				$display("%0t: saturated expected %0b actual %0b", $time, want.sat, sat);
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [OP_W-1:0]            opcode = OP_FILTER;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic [IDX_W-1:0]           coef_index = '0;
	logic signed [COEF_W-1:0]   coef_value = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       saturated;
	logic                       cfg_we = 1'b0;
	logic [ORDER_W-1:0]         cfg_data = '0;

	fir_scoreboard sb = new;
	bit            calm = 1'b0;
	int            cycles = 0;

	lpc_inverse_fir_filter #(
		.MAX_TAPS(NUM_TAPS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.sample_in (sample_in),
		.coef_index(coef_index),
		.coef_value(coef_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample_out(sample_out),
		.saturated (saturated),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, sb.pending());
			$display("lpc_inverse_fir_filter_test: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note_beat(opcode, sample_in, coef_index, coef_value);
		if (arst_n && out_valid && out_ready)
			sb.check_result(sample_out, saturated);
	end

	// result side: random stall before each beat
	initial begin
		int n;
		forever begin
			n = calm ? 0 : $urandom_range(0, 8);
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// valid stays high into the next beat when no gap is drawn
	task automatic send_beat(input logic [OP_W-1:0] op, input logic signed [SAMPLE_W-1:0] s,
			input logic [IDX_W-1:0] idx, input logic signed [COEF_W-1:0] c);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		sample_in  <= s;
		coef_index <= idx;
		coef_value <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		// loads and clears take effect on acceptance; this wait is only a margin
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_order(input logic [ORDER_W-1:0] v);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_order(v);
	endtask

	task automatic rand_beat();
		int                         pick;
		int                         tmp;
		logic signed [SAMPLE_W-1:0] s;
		logic signed [COEF_W-1:0]   c;
		logic [IDX_W-1:0]           idx;
		pick = $urandom_range(0, 99);
		s = SAMPLE_W'($urandom());
		if ($urandom_range(0, 7) == 0)
			s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		tmp = $urandom_range(0, 8191) - 4096;
		c = ($urandom_range(0, 9) == 0) ? COEF_W'($urandom()) : COEF_W'(tmp);
		idx = IDX_W'($urandom());
		if (pick < 72)
			send_beat(OP_FILTER, s, idx, c);
		else if (pick < 86)
			send_beat(OP_LOAD, s, idx, c);
		else if (pick < 93)
			send_beat(OP_CLEAR, s, idx, c);
		else
			send_beat(OP_NONE, s, idx, c);
	endtask

	initial begin
		logic [ORDER_W-1:0]       order_list[PHASES];
		logic signed [COEF_W-1:0] c;
		int                       tmp;
		order_list = '{6'd1, 6'd32, 6'd2, 6'd63, 6'd31, 6'd33, 6'd0, 6'd17};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// order zero after reset: output follows input
		send_beat(OP_FILTER, 16'sh7fff, 5'd0, 20'sd0);
		send_beat(OP_FILTER, 16'sh8000, 5'd0, 20'sd0);
		send_beat(OP_FILTER, -16'sd1, 5'd0, 20'sd0);
		send_beat(OP_LOAD, 16'sd0, 5'd0, 20'sh7ffff);
		send_beat(OP_LOAD, 16'sd0, 5'd31, 20'sh80000);
		send_beat(OP_LOAD, 16'sd0, 5'd1, -20'sd65536);
		send_beat(OP_NONE, 16'sh5a5a, 5'd3, 20'sh12345);

		// full order, drive both saturation directions
		write_order(6'd32);
		send_beat(OP_FILTER, 16'sh7fff, 5'd0, 20'sd0);
		send_beat(OP_FILTER, 16'sh7fff, 5'd0, 20'sd0);
		send_beat(OP_LOAD, 16'sd0, 5'd0, 20'sh80000);
		send_beat(OP_FILTER, 16'sh7fff, 5'd0, 20'sd0);
		send_beat(OP_FILTER, 16'sd0, 5'd0, 20'sd0);
		send_beat(OP_CLEAR, 16'sd0, 5'd0, 20'sd0);
		send_beat(OP_FILTER, 16'sd1000, 5'd0, 20'sd0);

		// order above the built tap count
		write_order(6'd63);
		send_beat(OP_FILTER, -16'sd20000, 5'd0, 20'sd0);
		send_beat(OP_FILTER, 16'sd20000, 5'd0, 20'sd0);

		// half coefficient on one tap gives rounding ties on both signs
		write_order(6'd1);
		send_beat(OP_LOAD, 16'sd0, 5'd0, 20'sd32768);
		send_beat(OP_CLEAR, 16'sd0, 5'd0, 20'sd0);
		send_beat(OP_FILTER, 16'sd1, 5'd0, 20'sd0);
		send_beat(OP_FILTER, 16'sd0, 5'd0, 20'sd0);
		send_beat(OP_FILTER, -16'sd1, 5'd0, 20'sd0);
		send_beat(OP_FILTER, 16'sd0, 5'd0, 20'sd0);

		for (int ph = 0; ph < PHASES; ph++) begin
			write_order(order_list[ph] == 6'd17 ? 6'($urandom_range(0, 63)) : order_list[ph]);
			calm = (ph % 4 == 3);
			// fresh set of mild coefficients so the output is not always clipped
			for (int k = 0; k < NUM_TAPS; k++) begin
				tmp = $urandom_range(0, 8191) - 4096;
				c = COEF_W'(tmp);
				send_beat(OP_LOAD, SAMPLE_W'($urandom()), IDX_W'(k), c);
			end
			for (int i = 0; i < BEATS_PER_PHASE; i++) begin
				if (i == BEATS_PER_PHASE / 2)
					drain();
				rand_beat();
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("lpc_inverse_fir_filter_test: PASS");
		end else begin
			if (sb.pending() > 0)
				$display("%0t: %0d expected results never came", $time, sb.pending());
			$display("lpc_inverse_fir_filter_test: FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/lpcinv_pkg.sv
hw/rtl/lpcinv_cell.sv
hw/rtl/lpc_inverse_fir_filter.sv
dv/lpc_inverse_fir_filter_test.sv
